@@ rtl/core/wlc_pkg.sv @@
// Shared types, codes and constants of the window layer compositor.
`default_nettype none

package wlc_pkg;

  // Default geometry
  localparam int MAX_WINDOWS_DEF   = 8;
  localparam int SCREEN_WIDTH_DEF  = 1280;
  localparam int SCREEN_HEIGHT_DEF = 800;
  localparam int CURSOR_SIZE_DEF   = 10;

  // Pointer scaling and window placement
  localparam int POINTER_FULL     = 32767;
  localparam int ADDED_TITLE_ROWS = 20;
  localparam int CASCADE_STEP     = 30;
  localparam int CASCADE_BASE     = 100;
  localparam int CASCADE_X_MOD    = 400;
  localparam int CASCADE_Y_MOD    = 300;
  localparam int POINTER_X_RESET  = 640;
  localparam int POINTER_Y_RESET  = 400;

  // Register reset values
  localparam logic [31:0] BACKGROUND_RESET = 32'hFF08113B;
  localparam logic [31:0] CURSOR_RESET     = 32'hFFFF0000;
  localparam logic [31:0] UNFOCUSED_RESET  = 32'hFF120A8F;
  localparam logic [31:0] FOCUSED_RESET    = 32'hFF00FFCB;
  localparam logic [5:0]  TITLE_ROWS_RESET = 6'd20;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BACKGROUND = 3'd0,
    CFG_CURSOR     = 3'd1,
    CFG_UNFOCUSED  = 3'd2,
    CFG_FOCUSED    = 3'd3,
    CFG_TITLE_ROWS = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_PTR_X  = 3'd1,
    OP_PTR_Y  = 3'd2,
    OP_BUTTON = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    SRC_BACKGROUND = 3'd0,
    SRC_FOCUSED    = 3'd1,
    SRC_UNFOCUSED  = 3'd2,
    SRC_CLIENT     = 3'd3,
    SRC_CURSOR     = 3'd4
  } src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR_UPD,
    ST_PTR_WR,
    ST_HIT,
    ST_RAISE,
    ST_MUL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [14:0] pointer_value;
    logic        button_down;
    logic [10:0] client_width;
    logic [9:0]  client_height;
    logic [10:0] query_x;
    logic [9:0]  query_y;
  } item_t;

  typedef struct packed {
    logic [2:0]  source;
    logic [31:0] pixel_color;
    logic [2:0]  window_slot;
    logic [19:0] buffer_offset;
    logic        table_full;
  } result_t;

  typedef struct packed {
    logic [31:0] background_color;
    logic [31:0] cursor_fill;
    logic [31:0] unfocused_title_color;
    logic [31:0] focused_title_color;
    logic [5:0]  title_bar_rows;
  } cfg_regs_t;

  // One window table entry; left and top are two's complement
  typedef struct packed {
    logic [12:0] left;
    logic [12:0] top;
    logic [10:0] width;
    logic [9:0]  height;
  } win_entry_t;

endpackage

`default_nettype wire

@@ rtl/core/wlc_in_if.sv @@
// Input item channel.
`default_nettype none

interface wlc_in_if import wlc_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wlc_out_if.sv @@
// Result item channel.
`default_nettype none

interface wlc_out_if import wlc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wlc_cfg_if.sv @@
// Configuration write channel.
`default_nettype none

interface wlc_cfg_if import wlc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [31:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wlc_scale.sv @@
// Pointer scaler: absolute 0..32767 coordinate to screen pixels.
`default_nettype none

module wlc_scale import wlc_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic        sel_y,
  input  wire logic [14:0] value,
  output logic [12:0]      scaled
);

  localparam int PW = 28;

  logic [PW-1:0] product;
  logic [12:0]   quot_hi;
  logic [15:0]   fold;

  // Register the product of value and screen extent
  always_ff @(posedge clk) begin
    if (load) begin
      product <= PW'(value) * PW'(sel_y ? 13'(SCREEN_HEIGHT) : 13'(SCREEN_WIDTH));
    end
  end

  // Divide by 2^15-1: high part plus one correction step
  always_comb begin
    quot_hi = product[PW-1:15];
    fold    = 16'(quot_hi) + 16'(product[14:0]);
    scaled  = quot_hi + 13'(fold >= 16'(POINTER_FULL));
  end

endmodule

`default_nettype wire

@@ rtl/core/wlc_engine.sv @@
// Window table and stack memories with the sequencer that serves each item.
`default_nettype none

module wlc_engine import wlc_pkg::*; #(
  parameter int MAX_WINDOWS   = MAX_WINDOWS_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int CURSOR_SIZE   = CURSOR_SIZE_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  cfg_regs_t  regs,
  wlc_in_if.sink     item,
  wlc_out_if.source  result
);

  localparam int SW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW = $clog2(MAX_WINDOWS + 1);
  localparam logic [CW-1:0] NO_SLOT = CW'(MAX_WINDOWS);
  localparam int LIM_X = (SCREEN_WIDTH > CURSOR_SIZE) ? SCREEN_WIDTH - CURSOR_SIZE : 0;
  localparam int LIM_Y = (SCREEN_HEIGHT > CURSOR_SIZE) ? SCREEN_HEIGHT - CURSOR_SIZE : 0;

  state_t state, state_next;

  // Memories
  win_entry_t tab_mem [MAX_WINDOWS];
  win_entry_t tab_q, tab_wd;
  logic [SW-1:0] tab_ra, tab_wa;
  logic tab_we;
  logic [SW-1:0] stk_mem [MAX_WINDOWS];
  logic [SW-1:0] stk_q, stk_wd, stk_ra, stk_wa;
  logic stk_we;

  // Persistent state
  logic [CW-1:0] window_count, focus_slot, drag_slot;
  logic          button_held;
  logic [10:0]   grab_dx, pointer_x, cursor_x;
  logic [9:0]    grab_dy, pointer_y, cursor_y;
  logic [15:0]   id_counter;
  logic [8:0]    casc_x, casc_y;

  // Work registers
  logic          is_query, is_y;
  logic [10:0]   hx;
  logic [9:0]    hy;
  logic [SW-1:0] ka, kb, kc, slot_c;
  logic          va, vb, vc, lastb, lastc;
  logic [SW-1:0] hit_slot;
  logic [10:0]   hit_dx, hit_width;
  logic [9:0]    hit_dy;
  logic          hit_title;
  logic [SW-1:0] rpos, raise_wa;
  logic          raise_pend;
  result_t       res;
  logic [19:0]   res_prod;
  logic [10:0]   res_dx;
  logic          out_valid;
  result_t       out_data;

  // Combinational helpers
  op_t           op;
  logic          item_fire, out_free, scale_load;
  logic [12:0]   scaled;
  logic          on_screen, on_cursor, drag_on, table_is_full;
  logic [15:0]   id_next;
  logic [8:0]    cx_next, cy_next;
  logic signed [14:0] c_dx, c_dy;
  logic          covers, title, hit_now;
  logic [SW-1:0] last_pos;
  logic [10:0]   cur_x_new;
  logic [9:0]    cur_y_new;

  assign op           = op_t'(item.data.operation);
  assign item.ready   = (state == ST_IDLE);
  assign item_fire    = item.valid && item.ready;
  assign out_free     = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign scale_load   = item_fire && (op == OP_PTR_X || op == OP_PTR_Y);
  assign drag_on      = button_held && (drag_slot != NO_SLOT);
  assign table_is_full = window_count >= CW'(MAX_WINDOWS);
  assign last_pos     = SW'(window_count - CW'(1));

  wlc_scale #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_scale (
    .clk    (clk),
    .load   (scale_load),
    .sel_y  (op == OP_PTR_Y),
    .value  (item.data.pointer_value),
    .scaled (scaled)
  );

  // Window table memory
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
    tab_q <= tab_mem[tab_ra];
  end

  // Stack order memory, position 0 is the bottom
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

  // Query point against screen and cursor
  always_comb begin
    on_screen = (13'(item.data.query_x) < 13'(SCREEN_WIDTH)) &&
                (13'(item.data.query_y) < 13'(SCREEN_HEIGHT));
    on_cursor = (12'(item.data.query_x) >= 12'(cursor_x)) &&
                (12'(item.data.query_x) < 12'(cursor_x) + 12'(CURSOR_SIZE)) &&
                (12'(item.data.query_y) >= 12'(cursor_y)) &&
                (12'(item.data.query_y) < 12'(cursor_y) + 12'(CURSOR_SIZE));
  end

  // Cascade placement steps
  always_comb begin
    logic [9:0] ax, ay;
    id_next = id_counter + 16'd1;
    ax = 10'(casc_x) + 10'(CASCADE_STEP);
    ay = 10'(casc_y) + 10'(CASCADE_STEP);
    cx_next = (ax >= 10'(CASCADE_X_MOD)) ? 9'(ax - 10'(CASCADE_X_MOD)) : 9'(ax);
    cy_next = (ay >= 10'(CASCADE_Y_MOD)) ? 9'(ay - 10'(CASCADE_Y_MOD)) : 9'(ay);
    if (id_next == 16'd0) begin
      cx_next = 9'd0;
      cy_next = 9'd0;
    end
  end

  // Cover test on the table entry read for the compare stage
  always_comb begin
    logic signed [14:0] l, t;
    l = {{2{tab_q.left[12]}}, tab_q.left};
    t = {{2{tab_q.top[12]}}, tab_q.top};
    c_dx = $signed({4'b0, hx}) - l;
    c_dy = $signed({5'b0, hy}) - t;
    covers = (c_dx >= 15'sd0) && (c_dx < $signed({4'b0, tab_q.width})) &&
             (c_dy >= 15'sd0) && (c_dy < $signed({5'b0, tab_q.height}));
    title = c_dy < $signed({9'b0, regs.title_bar_rows});
    hit_now = vc && covers;
  end

  // Clamped cursor positions
  always_comb begin
    cur_x_new = (scaled > 13'(LIM_X)) ? 11'(LIM_X) : scaled[10:0];
    cur_y_new = (scaled > 13'(LIM_Y)) ? 10'(LIM_Y) : scaled[9:0];
    if (13'(scaled[10:0]) > 13'(LIM_X)) begin
      cur_x_new = 11'(LIM_X);
    end else begin
      cur_x_new = scaled[10:0];
    end
    if (13'(scaled[9:0]) > 13'(LIM_Y)) begin
      cur_y_new = 10'(LIM_Y);
    end else begin
      cur_y_new = scaled[9:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory ports
  always_comb begin
    state_next = state;
    tab_ra = stk_q;
    tab_we = 1'b0;
    tab_wa = SW'(window_count);
    tab_wd = '0;
    stk_ra = ka;
    stk_we = 1'b0;
    stk_wa = SW'(window_count);
    stk_wd = SW'(window_count);
    case (state)
      ST_IDLE: begin
        if (item_fire) begin
          case (op)
            OP_ADD: begin
              if (!table_is_full) begin
                tab_we = 1'b1;
                tab_wd.left   = 13'(CASCADE_BASE) + 13'(cx_next);
                tab_wd.top    = 13'(CASCADE_BASE) + 13'(cy_next);
                tab_wd.width  = item.data.client_width;
                tab_wd.height = item.data.client_height + 10'(ADDED_TITLE_ROWS);
                stk_we = 1'b1;
              end
              state_next = ST_RESULT;
            end
            OP_PTR_X, OP_PTR_Y: state_next = ST_PTR_UPD;
            OP_BUTTON: begin
              if (item.data.button_down && window_count != '0) begin
                state_next = ST_HIT;
              end
            end
            OP_QUERY: begin
              if (on_screen && !on_cursor && window_count != '0) begin
                state_next = ST_HIT;
              end else begin
                state_next = ST_RESULT;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PTR_UPD: begin
        tab_ra = SW'(drag_slot);
        state_next = drag_on ? ST_PTR_WR : ST_IDLE;
      end
      ST_PTR_WR: begin
        tab_we = 1'b1;
        tab_wa = SW'(drag_slot);
        tab_wd = tab_q;
        tab_wd.left = 13'(pointer_x) - 13'(grab_dx);
        tab_wd.top  = 13'(pointer_y) - 13'(grab_dy);
        state_next = ST_IDLE;
      end
      ST_HIT: begin
        if (hit_now) begin
          state_next = is_query ? ST_MUL : ST_RAISE;
        end else if (vc && lastc) begin
          state_next = is_query ? ST_RESULT : ST_IDLE;
        end
      end
      ST_RAISE: begin
        stk_ra = rpos + SW'(1);
        if (raise_pend) begin
          stk_we = 1'b1;
          stk_wa = raise_wa;
          stk_wd = stk_q;
        end else if (rpos == last_pos) begin
          stk_we = 1'b1;
          stk_wa = last_pos;
          stk_wd = hit_slot;
          state_next = ST_IDLE;
        end
      end
      ST_MUL: state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Persistent state and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      focus_slot   <= NO_SLOT;
      drag_slot    <= NO_SLOT;
      button_held  <= 1'b0;
      grab_dx      <= '0;
      grab_dy      <= '0;
      pointer_x    <= 11'(POINTER_X_RESET);
      pointer_y    <= 10'(POINTER_Y_RESET);
      cursor_x     <= 11'(POINTER_X_RESET);
      cursor_y     <= 10'(POINTER_Y_RESET);
      id_counter   <= 16'd1;
      casc_x       <= 9'(CASCADE_STEP);
      casc_y       <= 9'(CASCADE_STEP);
      va           <= 1'b0;
      vb           <= 1'b0;
      vc           <= 1'b0;
      raise_pend   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Drop the result once transferred
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          va <= 1'b0;
          vb <= 1'b0;
          vc <= 1'b0;
          res      <= '0;
          res_prod <= '0;
          res_dx   <= '0;
          is_query <= (op == OP_QUERY);
          is_y     <= (op == OP_PTR_Y);
          ka       <= last_pos;
          if (item_fire) begin
            case (op)
              OP_ADD: begin
                if (table_is_full) begin
                  res.table_full <= 1'b1;
                end else begin
                  id_counter   <= id_next;
                  casc_x       <= cx_next;
                  casc_y       <= cy_next;
                  window_count <= window_count + CW'(1);
                  focus_slot   <= window_count;
                  res.window_slot <= 3'(window_count);
                end
              end
              OP_BUTTON: begin
                button_held <= item.data.button_down;
                hx <= pointer_x;
                hy <= pointer_y;
                if (item.data.button_down) begin
                  va <= (window_count != '0);
                end else begin
                  drag_slot <= NO_SLOT;
                end
              end
              OP_QUERY: begin
                hx <= item.data.query_x;
                hy <= item.data.query_y;
                if (!on_screen) begin
                  res.pixel_color <= regs.background_color;
                end else if (on_cursor) begin
                  res.source      <= SRC_CURSOR;
                  res.pixel_color <= regs.cursor_fill;
                end else begin
                  res.pixel_color <= regs.background_color;
                  va <= (window_count != '0);
                end
              end
              default: ;
            endcase
          end
        end
        ST_PTR_UPD: begin
          if (is_y) begin
            pointer_y <= scaled[9:0];
            cursor_y  <= cur_y_new;
          end else begin
            pointer_x <= scaled[10:0];
            cursor_x  <= cur_x_new;
          end
        end
        ST_HIT: begin
          // Advance the three-stage read pipeline, topmost position first
          va    <= va && (ka != '0);
          ka    <= ka - SW'(1);
          vb    <= va;
          kb    <= ka;
          lastb <= (ka == '0);
          vc    <= vb;
          kc    <= kb;
          lastc <= lastb;
          slot_c <= stk_q;
          if (hit_now) begin
            hit_slot  <= slot_c;
            hit_dx    <= c_dx[10:0];
            hit_dy    <= c_dy[9:0];
            hit_title <= title;
            hit_width <= tab_q.width;
            rpos       <= kc;
            raise_pend <= 1'b0;
            if (!is_query) begin
              focus_slot <= CW'(slot_c);
              if (title) begin
                drag_slot <= CW'(slot_c);
                grab_dx   <= c_dx[10:0];
                grab_dy   <= c_dy[9:0];
              end
            end
          end
        end
        ST_RAISE: begin
          if (rpos != last_pos) begin
            raise_wa   <= rpos;
            rpos       <= rpos + SW'(1);
            raise_pend <= 1'b1;
          end else begin
            raise_pend <= 1'b0;
          end
        end
        ST_MUL: begin
          res.window_slot <= 3'(hit_slot);
          if (hit_title) begin
            if (CW'(hit_slot) == focus_slot) begin
              res.source      <= SRC_FOCUSED;
              res.pixel_color <= regs.focused_title_color;
            end else begin
              res.source      <= SRC_UNFOCUSED;
              res.pixel_color <= regs.unfocused_title_color;
            end
          end else begin
            res.source      <= SRC_CLIENT;
            res.pixel_color <= '0;
            res_prod <= 20'((hit_dy - 10'(regs.title_bar_rows)) * 21'(hit_width));
            res_dx   <= hit_dx;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res;
            out_data.buffer_offset <= res_prod + 20'(res_dx);
          end
        end
        default: ;
      endcase
    end
  end

  // Checks on table bookkeeping
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    window_count <= CW'(MAX_WINDOWS))
    else $error("window count above table size");

  a_focus_valid: assert property (@(posedge clk) disable iff (rst)
    (focus_slot == NO_SLOT) || (focus_slot < window_count))
    else $error("focus mark on an empty slot");

  a_drag_valid: assert property (@(posedge clk) disable iff (rst)
    (drag_slot != NO_SLOT) |-> (drag_slot < window_count))
    else $error("drag on an empty slot");

  a_raise_pend: assert property (@(posedge clk) disable iff (rst)
    raise_pend |-> (state == ST_RAISE))
    else $error("stack move pending outside raise");

endmodule

`default_nettype wire

@@ rtl/core/window_layer_compositor_top.sv @@
// Top level of the window layer compositor: configuration registers and engine.
`default_nettype none

// Window layer compositor. Items enter on item and at most one result per item
// leaves on result; add and pixel query give a result, pointer and button items
// give none. An item is taken only when the previous one is finished, though a
// finished result may still wait in the output register. A pointer move during
// a drag also writes the dragged window back to the window table memory. Press
// and query walk the stack memory from the top, one stack position per cycle
// behind a read pipeline of stack read, table read and compare; a query that
// hits goes on to the offset multiply. A press that hits puts the window on top
// and, when it was not on top already, moves the stack entries above it down
// one at a time, limited by the single write port of the stack memory.
// Configuration writes are taken every cycle.
module window_layer_compositor_top import wlc_pkg::*; #(
  parameter int MAX_WINDOWS   = MAX_WINDOWS_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int CURSOR_SIZE   = CURSOR_SIZE_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  wlc_cfg_if.sink   cfg,
  wlc_in_if.sink    item,
  wlc_out_if.source result
);

  cfg_regs_t regs;

  assign cfg.ready = 1'b1;

  // Hold the configuration registers; update on a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.background_color      <= BACKGROUND_RESET;
      regs.cursor_fill           <= CURSOR_RESET;
      regs.unfocused_title_color <= UNFOCUSED_RESET;
      regs.focused_title_color   <= FOCUSED_RESET;
      regs.title_bar_rows        <= TITLE_ROWS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        CFG_BACKGROUND: regs.background_color      <= cfg.data;
        CFG_CURSOR:     regs.cursor_fill           <= cfg.data;
        CFG_UNFOCUSED:  regs.unfocused_title_color <= cfg.data;
        CFG_FOCUSED:    regs.focused_title_color   <= cfg.data;
        CFG_TITLE_ROWS: regs.title_bar_rows        <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  wlc_engine #(
    .MAX_WINDOWS   (MAX_WINDOWS),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .CURSOR_SIZE   (CURSOR_SIZE)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .item   (item),
    .result (result)
  );

endmodule

`default_nettype wire
